### hw/rtl/pthc_pkg.sv
// shared types, constants and helper functions for the sensor compensation core
`default_nettype none

package pthc_pkg;

    localparam int CFG_DATA_W  = 48;
    localparam int REG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEPS   = 64;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [REG_IDX_W-1:0] REG_TEMP    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESS_A = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PRESS_B = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PRESS_C = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_HUMID_A = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_HUMID_B = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_T_OFF = 2'd1;
    localparam logic [1:0] ST_P_OFF = 2'd2;
    localparam logic [1:0] ST_H_OFF = 2'd3;

    localparam logic [23:0] DISABLED_TP = 24'h800000;
    localparam logic [15:0] DISABLED_H  = 16'h8000;
    localparam logic [63:0] T_FINE_PREF = 64'd128000;
    localparam logic [63:0] P_OFFSET    = 64'd1048576;
    localparam logic [63:0] P_SCALE     = 64'd3125;
    localparam logic [63:0] P_BIAS      = 64'd1 << 47;
    localparam logic [63:0] H_TF_OFFSET = 64'd76800;
    localparam logic [63:0] H_ROUND     = 64'd16384;
    localparam logic [63:0] H_HALF      = 64'd32768;
    localparam logic [63:0] H_BIAS      = 64'd2097152;
    localparam logic [63:0] H_MID       = 64'd8192;
    localparam logic [63:0] H_LIMIT     = 64'd419430400;
    localparam logic [63:0] T_ROUND     = 64'd128;

    typedef struct packed {
        logic [23:0] raw_temperature;
        logic [23:0] raw_pressure;
        logic [15:0] raw_humidity;
    } sample_t;

    typedef struct packed {
        logic signed [16:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic [16:0]        humidity_q22_10;
        logic [1:0]         result_status;
    } result_t;

    typedef struct packed {
        sample_t sample;
        logic    t_off;
        logic    p_off;
        logic    h_off;
    } entry_t;

    typedef struct packed {
        logic [47:0] temp;
        logic [47:0] press_a;
        logic [47:0] press_b;
        logic [47:0] press_c;
        logic [31:0] humid_a;
        logic [31:0] humid_b;
    } coeff_t;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } op_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } op_rsp_t;

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        return 64'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] sx12(input logic [11:0] v);
        return {{52{v[11]}}, v};
    endfunction

    function automatic logic [63:0] sx8(input logic [7:0] v);
        return {{56{v[7]}}, v};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pthc_front.sv
// input stage: takes items, flags disabled channels, hands them to the queue
`default_nettype none

module pthc_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire pthc_pkg::sample_t sample,
    input  wire logic             full,
    output logic                  push,
    output pthc_pkg::entry_t      entry
);
    import pthc_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    logic   accept;

    assign push   = valid_reg && !full;
    assign busy   = valid_reg && full;
    assign accept = start && !busy;
    assign entry  = entry_reg;

    always_comb
    begin
        valid_next = accept || (valid_reg && !push);
        entry_next = entry_reg;
        if (accept)
        begin
            entry_next.sample = sample;
            entry_next.t_off  = (sample.raw_temperature == DISABLED_TP);
            entry_next.p_off  = (sample.raw_pressure == DISABLED_TP);
            entry_next.h_off  = (sample.raw_humidity == DISABLED_H);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

### hw/rtl/pthc_queue.sv
// short fifo between the input stage and the compute sequencer
`default_nettype none

module pthc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire pthc_pkg::entry_t push_entry,
    input  wire logic            pop,
    output pthc_pkg::entry_t     head,
    output logic                 empty,
    output logic                 full
);
    import pthc_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pthc_mul.sv
// 64-bit wrapping multiplier, low half of the product from three 32x32 passes
`default_nettype none

module pthc_mul (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pthc_pkg::op_req_t req,
    output pthc_pkg::op_rsp_t     rsp
);
    import pthc_pkg::*;

    typedef enum logic [1:0] {PH_LL, PH_LH, PH_HL} phase_t;

    phase_t      phase_reg;
    logic        run_reg;
    logic        done_reg;
    logic [63:0] a_reg, b_reg, lo_reg, p_reg;
    logic [31:0] cr_reg;
    logic [31:0] op_x, op_y;
    logic [63:0] prod;

    always_comb
    begin
        case (phase_reg)
            PH_LL:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
            PH_LH:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            PH_HL:
            begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
            default:
            begin
                op_x = '0;
                op_y = '0;
            end
        endcase
        prod = op_x * op_y;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LL;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg   <= 1'b1;
                phase_reg <= PH_LL;
            end
            else if (run_reg)
            begin
                case (phase_reg)
                    PH_LL:   phase_reg <= PH_LH;
                    PH_LH:   phase_reg <= PH_HL;
                    default:
                    begin
                        run_reg  <= 1'b0;
                        done_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= req.a;
            b_reg <= req.b;
        end
        else if (run_reg)
        begin
            case (phase_reg)
                PH_LL:   lo_reg <= prod;
                PH_LH:   cr_reg <= prod[31:0];
                default: p_reg  <= lo_reg + {cr_reg + prod[31:0], 32'b0};
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pthc_div.sv
// signed 64-bit divider, truncating, one quotient bit per cycle
`default_nettype none

module pthc_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pthc_pkg::op_req_t req,
    output pthc_pkg::op_rsp_t     rsp
);
    import pthc_pkg::*;

    logic                 run_reg;
    logic                 done_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [63:0]          n_reg, d_reg, r_reg, q_reg;
    logic [64:0]          r_shift;
    logic                 fits;
    logic [63:0]          r_new, n_new;

    always_comb
    begin
        r_shift = {r_reg, n_reg[63]};
        fits    = (r_shift >= {1'b0, d_reg});
        r_new   = fits ? 64'(r_shift - {1'b0, d_reg}) : r_shift[63:0];
        n_new   = {n_reg[62:0], fits};
    end

    assign rsp.done  = done_reg;
    assign rsp.value = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            n_reg   <= req.a[63] ? 64'(0 - req.a) : req.a;
            d_reg   <= req.b[63] ? 64'(0 - req.b) : req.b;
            r_reg   <= '0;
            neg_reg <= req.a[63] ^ req.b[63];
        end
        else if (run_reg)
        begin
            r_reg <= r_new;
            n_reg <= n_new;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                q_reg <= neg_reg ? 64'(0 - n_new) : n_new;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pthc_back.sv
// compute sequencer: temperature, pressure and humidity on shared mul and div units
`default_nettype none

module pthc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pthc_pkg::coeff_t  coeffs,
    input  wire pthc_pkg::entry_t  head,
    input  wire logic             empty,
    output logic                  pop,
    output pthc_pkg::op_req_t     mul_req,
    input  wire pthc_pkg::op_rsp_t mul_rsp,
    output pthc_pkg::op_req_t     div_req,
    input  wire pthc_pkg::op_rsp_t div_rsp,
    output logic                  done,
    output pthc_pkg::result_t     result
);
    import pthc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_T0, S_T1, S_T2, S_T3,
        S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_PDIV, S_P7, S_P8, S_P9,
        S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8, S_FIN
    } state_t;

    state_t      state_reg, state_next;
    logic        launched_reg, launched_next;
    entry_t      cur_reg, cur_next;
    logic [63:0] tf_reg, tf_next;
    logic [63:0] v1_reg, v1_next;
    logic [63:0] v2_reg, v2_next;
    logic [63:0] sq_reg, sq_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] p_reg, p_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [16:0] temp_reg, temp_next;
    logic [31:0] press_reg, press_next;
    logic [16:0] hum_reg, hum_next;
    logic [1:0]  status_reg, status_next;
    logic        done_reg, done_next;
    result_t     result_reg, result_next;

    logic        mul_go, div_go;
    logic [63:0] ma, mb;
    logic [63:0] m, st, hv, v1_new, p_fin;
    logic [19:0] adc_t, adc_p;

    assign adc_t = cur_reg.sample.raw_temperature[23:4];
    assign adc_p = cur_reg.sample.raw_pressure[23:4];
    assign m     = mul_rsp.value;

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        tf_next     = tf_reg;
        v1_next     = v1_reg;
        v2_next     = v2_reg;
        sq_next     = sq_reg;
        acc_next    = acc_reg;
        p_next      = p_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        temp_next   = temp_reg;
        press_next  = press_reg;
        hum_next    = hum_reg;
        status_next = status_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        pop         = 1'b0;
        mul_go      = 1'b0;
        div_go      = 1'b0;
        ma          = '0;
        mb          = '0;
        st          = asr64((tf_reg << 2) + tf_reg + T_ROUND, 8);
        v1_new      = asr64(m, 33);
        p_fin       = asr64(p_reg + acc_reg + asr64(m, 19), 8) + (sx16(coeffs.press_c[15:0]) << 4);
        hv          = v2_reg - asr64(m, 4);

        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop         = 1'b1;
                    cur_next    = head;
                    temp_next   = '0;
                    press_next  = '0;
                    hum_next    = '0;
                    status_next = ST_OK;
                    if (head.t_off)
                    begin
                        status_next = ST_T_OFF;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_T0;
                    end
                end
            end
            S_T0:
            begin
                mul_go = 1'b1;
                ma = {47'b0, adc_t[19:3]} - {47'b0, coeffs.temp[15:0], 1'b0};
                mb = sx16(coeffs.temp[31:16]);
                if (mul_rsp.done)
                begin
                    v1_next    = asr64(m, 11);
                    state_next = S_T1;
                end
            end
            S_T1:
            begin
                mul_go = 1'b1;
                ma = {48'b0, adc_t[19:4]} - {48'b0, coeffs.temp[15:0]};
                mb = ma;
                if (mul_rsp.done)
                begin
                    acc_next   = asr64(m, 12);
                    state_next = S_T2;
                end
            end
            S_T2:
            begin
                mul_go = 1'b1;
                ma = acc_reg;
                mb = sx16(coeffs.temp[47:32]);
                if (mul_rsp.done)
                begin
                    tf_next    = v1_reg + asr64(m, 14);
                    state_next = S_T3;
                end
            end
            S_T3:
            begin
                if ($signed(st) < -64'sd65536)
                begin
                    temp_next = 17'h10000;
                end
                else if ($signed(st) > 64'sd65535)
                begin
                    temp_next = 17'h0FFFF;
                end
                else
                begin
                    temp_next = st[16:0];
                end
                v1_next = tf_reg - T_FINE_PREF;
                if (cur_reg.p_off)
                begin
                    status_next = ST_P_OFF;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_P0;
                end
            end
            S_P0:
            begin
                mul_go = 1'b1;
                ma = v1_reg;
                mb = v1_reg;
                if (mul_rsp.done)
                begin
                    sq_next    = m;
                    state_next = S_P1;
                end
            end
            S_P1:
            begin
                mul_go = 1'b1;
                ma = sq_reg;
                mb = sx16(coeffs.press_b[47:32]);
                if (mul_rsp.done)
                begin
                    v2_next    = m;
                    state_next = S_P2;
                end
            end
            S_P2:
            begin
                mul_go = 1'b1;
                ma = v1_reg;
                mb = sx16(coeffs.press_b[31:16]);
                if (mul_rsp.done)
                begin
                    v2_next    = v2_reg + (m << 17) + (sx16(coeffs.press_b[15:0]) << 35);
                    state_next = S_P3;
                end
            end
            S_P3:
            begin
                mul_go = 1'b1;
                ma = sq_reg;
                mb = sx16(coeffs.press_a[47:32]);
                if (mul_rsp.done)
                begin
                    acc_next   = asr64(m, 8);
                    state_next = S_P4;
                end
            end
            S_P4:
            begin
                mul_go = 1'b1;
                ma = v1_reg;
                mb = sx16(coeffs.press_a[31:16]);
                if (mul_rsp.done)
                begin
                    acc_next   = acc_reg + (m << 12);
                    state_next = S_P5;
                end
            end
            S_P5:
            begin
                mul_go = 1'b1;
                ma = P_BIAS + acc_reg;
                mb = {48'b0, coeffs.press_a[15:0]};
                if (mul_rsp.done)
                begin
                    v1_next = v1_new;
                    // zero divisor leaves pressure at zero
                    if (v1_new == '0)
                    begin
                        state_next = S_H0;
                    end
                    else
                    begin
                        acc_next   = ((P_OFFSET - {44'b0, adc_p}) << 31) - v2_reg;
                        state_next = S_P6;
                    end
                end
            end
            S_P6:
            begin
                mul_go = 1'b1;
                ma = acc_reg;
                mb = P_SCALE;
                if (mul_rsp.done)
                begin
                    acc_next   = m;
                    state_next = S_PDIV;
                end
            end
            S_PDIV:
            begin
                div_go = 1'b1;
                if (div_rsp.done)
                begin
                    p_next     = div_rsp.value;
                    state_next = S_P7;
                end
            end
            S_P7:
            begin
                mul_go = 1'b1;
                ma = sx16(coeffs.press_c[47:32]);
                mb = asr64(p_reg, 13);
                if (mul_rsp.done)
                begin
                    acc_next   = m;
                    state_next = S_P8;
                end
            end
            S_P8:
            begin
                mul_go = 1'b1;
                ma = acc_reg;
                mb = asr64(p_reg, 13);
                if (mul_rsp.done)
                begin
                    acc_next   = asr64(m, 25);
                    state_next = S_P9;
                end
            end
            S_P9:
            begin
                mul_go = 1'b1;
                ma = sx16(coeffs.press_c[31:16]);
                mb = p_reg;
                if (mul_rsp.done)
                begin
                    press_next = p_fin[31:0];
                    state_next = S_H0;
                end
            end
            S_H0:
            begin
                v1_next = tf_reg - H_TF_OFFSET;
                if (cur_reg.h_off)
                begin
                    status_next = ST_H_OFF;
                    state_next  = S_FIN;
                end
                else
                begin
                    state_next = S_H1;
                end
            end
            S_H1:
            begin
                mul_go = 1'b1;
                ma = sx12(coeffs.humid_b[23:12]);
                mb = v1_reg;
                if (mul_rsp.done)
                begin
                    x_next = asr64({34'b0, cur_reg.sample.raw_humidity, 14'b0}
                                   - (sx12(coeffs.humid_b[11:0]) << 20) - m + H_ROUND, 15);
                    state_next = S_H2;
                end
            end
            S_H2:
            begin
                mul_go = 1'b1;
                ma = v1_reg;
                mb = sx8(coeffs.humid_b[31:24]);
                if (mul_rsp.done)
                begin
                    acc_next   = asr64(m, 10);
                    state_next = S_H3;
                end
            end
            S_H3:
            begin
                mul_go = 1'b1;
                ma = v1_reg;
                mb = {56'b0, coeffs.humid_a[31:24]};
                if (mul_rsp.done)
                begin
                    y_next     = asr64(m, 11) + H_HALF;
                    state_next = S_H4;
                end
            end
            S_H4:
            begin
                mul_go = 1'b1;
                ma = acc_reg;
                mb = y_reg;
                if (mul_rsp.done)
                begin
                    y_next     = asr64(m, 10) + H_BIAS;
                    state_next = S_H5;
                end
            end
            S_H5:
            begin
                mul_go = 1'b1;
                ma = y_reg;
                mb = sx16(coeffs.humid_a[23:8]);
                if (mul_rsp.done)
                begin
                    y_next     = asr64(m + H_MID, 14);
                    state_next = S_H6;
                end
            end
            S_H6:
            begin
                mul_go = 1'b1;
                ma = x_reg;
                mb = y_reg;
                if (mul_rsp.done)
                begin
                    v2_next    = m;
                    acc_next   = asr64(m, 15);
                    state_next = S_H7;
                end
            end
            S_H7:
            begin
                mul_go = 1'b1;
                ma = acc_reg;
                mb = acc_reg;
                if (mul_rsp.done)
                begin
                    acc_next   = asr64(m, 7);
                    state_next = S_H8;
                end
            end
            S_H8:
            begin
                mul_go = 1'b1;
                ma = acc_reg;
                mb = {56'b0, coeffs.humid_a[7:0]};
                if (mul_rsp.done)
                begin
                    if (hv[63])
                    begin
                        hum_next = '0;
                    end
                    else if (hv > H_LIMIT)
                    begin
                        hum_next = H_LIMIT[28:12];
                    end
                    else
                    begin
                        hum_next = hv[28:12];
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                done_next                     = 1'b1;
                result_next.temperature_centi = temp_reg;
                result_next.pressure_q24_8    = press_reg;
                result_next.humidity_q22_10   = hum_reg;
                result_next.result_status     = status_reg;
                state_next                    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        mul_req.start = mul_go && !launched_reg;
        mul_req.a     = ma;
        mul_req.b     = mb;
        div_req.start = div_go && !launched_reg;
        div_req.a     = acc_reg;
        div_req.b     = v1_reg;

        // one launch per step, cleared when the unit answers
        if (mul_rsp.done || div_rsp.done)
        begin
            launched_next = 1'b0;
        end
        else if (mul_req.start || div_req.start)
        begin
            launched_next = 1'b1;
        end
        else
        begin
            launched_next = launched_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            launched_reg <= 1'b0;
            cur_reg      <= '0;
            tf_reg       <= '0;
            v1_reg       <= '0;
            v2_reg       <= '0;
            sq_reg       <= '0;
            acc_reg      <= '0;
            p_reg        <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            temp_reg     <= '0;
            press_reg    <= '0;
            hum_reg      <= '0;
            status_reg   <= ST_OK;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
            cur_reg      <= cur_next;
            tf_reg       <= tf_next;
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            sq_reg       <= sq_next;
            acc_reg      <= acc_next;
            p_reg        <= p_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            temp_reg     <= temp_next;
            press_reg    <= press_next;
            hum_reg      <= hum_next;
            status_reg   <= status_next;
            done_reg     <= done_next;
            result_reg   <= result_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/pth_sensor_compensation_core.sv
// Integer compensation of raw pressure, humidity and temperature samples.
// An item (one raw sample triple) is taken at a clock edge where start is
// high and busy is low. Items land in an input register and a two-entry
// queue, so up to three items are taken one per cycle while the sequencer
// works; busy rises only when all of that is full.
// Each item gives one result, shown for one cycle on result with done high.
// The receiver cannot hold results off. Results come out in item order.
// On a full item the sequencer makes 21 passes through the shared
// 64-bit multiplier (three 32x32 partial products each), one radix-2
// division for pressure (64 quotient bits) and four steps that use
// neither unit. A disabled temperature goes straight to the result;
// the other disabled channels cut the run short. An item passes the
// input register and the queue, where it may wait behind earlier items.
// Coefficients are written through wr_en, wr_index and wr_data; the user
// must write them only while idle, which the block does not enforce.
// Reset clears coefficients, the queue and the sequencer.
`default_nettype none

module pth_sensor_compensation_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire pthc_pkg::sample_t             sample,
    output logic                               done,
    output pthc_pkg::result_t                  result,
    input  wire logic                          wr_en,
    input  wire logic [pthc_pkg::REG_IDX_W-1:0] wr_index,
    input  wire logic [pthc_pkg::CFG_DATA_W-1:0] wr_data
);
    import pthc_pkg::*;

    coeff_t  coeffs_reg;
    logic    q_push, q_pop, q_empty, q_full;
    entry_t  q_in, q_head;
    op_req_t mul_req, div_req;
    op_rsp_t mul_rsp, div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeffs_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TEMP:    coeffs_reg.temp    <= wr_data;
                REG_PRESS_A: coeffs_reg.press_a <= wr_data;
                REG_PRESS_B: coeffs_reg.press_b <= wr_data;
                REG_PRESS_C: coeffs_reg.press_c <= wr_data;
                REG_HUMID_A: coeffs_reg.humid_a <= wr_data[31:0];
                REG_HUMID_B: coeffs_reg.humid_b <= wr_data[31:0];
                default:     coeffs_reg <= coeffs_reg;
            endcase
        end
    end

    pthc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .sample (sample),
        .full   (q_full),
        .push   (q_push),
        .entry  (q_in)
    );

    pthc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    pthc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    pthc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pthc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .coeffs  (coeffs_reg),
        .head    (q_head),
        .empty   (q_empty),
        .pop     (q_pop),
        .mul_req (mul_req),
        .mul_rsp (mul_rsp),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .done    (done),
        .result  (result)
    );

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_t_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.result_status == ST_T_OFF |->
        result.temperature_centi == '0 && result.pressure_q24_8 == '0
        && result.humidity_q22_10 == '0)
        else $error("disabled temperature gave nonzero fields");

    a_p_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.result_status == ST_P_OFF |->
        result.pressure_q24_8 == '0 && result.humidity_q22_10 == '0)
        else $error("disabled pressure gave nonzero fields");

    a_mul_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |=> !mul_rsp.done)
        else $error("multiplier answered too early");
`endif

endmodule

`default_nettype wire
